// File: src/mrrc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus read response checker.
`default_nettype none

package mrrc_pkg;

    // One input word: a received byte or one time tick.
    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in;

    // One result word: raw reading and frame status.
    typedef struct packed {
        logic [31:0] reading;
        logic [1:0]  status;
    } t_out;

    // Input word kinds.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_CRC  = 2'd1;
    localparam logic [1:0] STATUS_TIME = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FUNCTION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT  = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration reset values.
    localparam logic [7:0]  RST_ADDRESS  = 8'h01;
    localparam logic [7:0]  RST_FUNCTION = 8'h03;
    localparam logic [15:0] RST_TIMEOUT  = 16'd500;

    // Frame phases: the number of bytes taken so far.
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_FUNC   = 4'd1;
    localparam logic [3:0] PH_COUNT  = 4'd2;
    localparam logic [3:0] PH_DATA0  = 4'd3;
    localparam logic [3:0] PH_DATA1  = 4'd4;
    localparam logic [3:0] PH_DATA2  = 4'd5;
    localparam logic [3:0] PH_DATA3  = 4'd6;
    localparam logic [3:0] PH_CRC_LO = 4'd7;
    localparam logic [3:0] PH_CRC_HI = 4'd8;

    // Frame constants.
    localparam logic [7:0]  BYTE_COUNT = 8'h04;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] TICKS_MAX  = 16'hFFFF;

    // Reflected CRC-16 update over one byte, one bit per step.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/mrrc_parser.sv
// Frame parser: phase counter, running CRC, data shifter and tick counter.
`default_nettype none

module mrrc_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire mrrc_pkg::t_in      i_item,
    input  wire logic [7:0]         i_exp_address,
    input  wire logic [7:0]         i_exp_function,
    input  wire logic [15:0]        i_timeout_ticks,
    output logic                    o_res_valid,
    output mrrc_pkg::t_out          o_res
);

    logic [3:0]  r_phase,   n_phase;
    logic [15:0] r_crc,     n_crc;
    logic [31:0] r_shift,   n_shift;
    logic [7:0]  r_crc_lo,  n_crc_lo;
    logic [15:0] r_ticks,   n_ticks;

    logic [15:0] ticks_inc;
    logic [15:0] crc_next;
    logic        crc_good;

    // Saturating tick count and the CRC after the current byte.
    assign ticks_inc = (r_ticks == mrrc_pkg::TICKS_MAX) ? r_ticks : r_ticks + 16'd1;
    assign crc_next  = mrrc_pkg::crc_feed(r_crc, i_item.rx_byte);
    assign crc_good  = (r_crc_lo == r_crc[7:0]) && (i_item.rx_byte == r_crc[15:8]);

    // Next state and result for one accepted word.
    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_shift     = r_shift;
        n_crc_lo    = r_crc_lo;
        n_ticks     = r_ticks;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (r_phase == mrrc_pkg::PH_IDLE || r_phase > mrrc_pkg::PH_CRC_HI) begin
                // Hunt for the address byte; ticks are ignored while idle.
                if (i_item.req_type == mrrc_pkg::REQ_BYTE &&
                    i_item.rx_byte == i_exp_address) begin
                    n_phase  = mrrc_pkg::PH_FUNC;
                    n_crc    = mrrc_pkg::crc_feed(mrrc_pkg::CRC_INIT, i_item.rx_byte);
                    n_shift  = '0;
                    n_crc_lo = '0;
                    n_ticks  = '0;
                end
            end else if (i_item.req_type == mrrc_pkg::REQ_TICK) begin
                // Count ticks inside the frame and abandon it once over the limit.
                n_ticks = ticks_inc;
                if (ticks_inc > i_timeout_ticks) begin
                    n_phase        = mrrc_pkg::PH_IDLE;
                    n_crc          = mrrc_pkg::CRC_INIT;
                    n_shift        = '0;
                    n_crc_lo       = '0;
                    n_ticks        = '0;
                    o_res_valid    = 1'b1;
                    o_res.reading  = '0;
                    o_res.status   = mrrc_pkg::STATUS_TIME;
                end
            end else begin
                case (r_phase)
                    mrrc_pkg::PH_FUNC, mrrc_pkg::PH_COUNT: begin
                        // Header bytes: a mismatch drops the frame silently.
                        if ((r_phase == mrrc_pkg::PH_FUNC &&
                             i_item.rx_byte != i_exp_function) ||
                            (r_phase == mrrc_pkg::PH_COUNT &&
                             i_item.rx_byte != mrrc_pkg::BYTE_COUNT)) begin
                            n_phase  = mrrc_pkg::PH_IDLE;
                            n_crc    = mrrc_pkg::CRC_INIT;
                            n_shift  = '0;
                            n_crc_lo = '0;
                            n_ticks  = '0;
                        end else begin
                            n_crc   = crc_next;
                            n_phase = r_phase + 4'd1;
                        end
                    end
                    mrrc_pkg::PH_DATA0, mrrc_pkg::PH_DATA1,
                    mrrc_pkg::PH_DATA2, mrrc_pkg::PH_DATA3: begin
                        n_shift = {r_shift[23:0], i_item.rx_byte};
                        n_crc   = crc_next;
                        n_phase = r_phase + 4'd1;
                    end
                    mrrc_pkg::PH_CRC_LO: begin
                        n_crc_lo = i_item.rx_byte;
                        n_phase  = mrrc_pkg::PH_CRC_HI;
                    end
                    default: begin
                        // Last byte: compare the CRC and hand out the reading.
                        o_res_valid   = 1'b1;
                        o_res.reading = r_shift;
                        o_res.status  = crc_good ? mrrc_pkg::STATUS_OK : mrrc_pkg::STATUS_CRC;
                        n_phase       = mrrc_pkg::PH_IDLE;
                        n_crc         = mrrc_pkg::CRC_INIT;
                        n_shift       = '0;
                        n_crc_lo      = '0;
                        n_ticks       = '0;
                    end
                endcase
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mrrc_pkg::PH_IDLE;
            r_crc    <= mrrc_pkg::CRC_INIT;
            r_shift  <= '0;
            r_crc_lo <= '0;
            r_ticks  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_shift  <= n_shift;
            r_crc_lo <= n_crc_lo;
            r_ticks  <= n_ticks;
        end
    end

endmodule

`default_nettype wire

// File: src/modbus_read_response_checker.sv
// Top level of the Modbus RTU read response checker.
//
// The input channel carries one word per received UART byte or per time tick
// (i_valid / o_stall, payload i_data). The result channel carries the 32-bit
// raw reading and a status (o_valid / i_stall, payload o_data): frame good,
// CRC mismatch, or timeout with a zero reading.
// A word is processed in the cycle it is accepted; a result appears on the
// output register in the cycle after the word that completes the frame or the
// tick that exceeds the limit. One word is taken every cycle unless stalled;
// the byte CRC update into the frame state registers is combinational. The
// input is stalled only while a result waits in the output register and the
// receiver holds i_stall; the result then stays unchanged. Configuration
// (address, function code, tick limit) is written through i_cfg_we /
// i_cfg_index / i_cfg_data; the user must write it only while the block is
// idle; the block does not enforce this. Synchronous reset restores address 1,
// function 3, a 500 tick limit and an empty frame; no result is then pending.
`default_nettype none

module modbus_read_response_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire mrrc_pkg::t_in                        i_data,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output mrrc_pkg::t_out                            o_data,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mrrc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [mrrc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [7:0]     r_exp_address;
    logic [7:0]     r_exp_function;
    logic [15:0]    r_timeout_ticks;
    logic           r_out_valid;
    mrrc_pkg::t_out r_out;

    logic           accept;
    logic           res_valid;
    mrrc_pkg::t_out res;

    // Hold off new words only while a result is stuck in the output register.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_address   <= mrrc_pkg::RST_ADDRESS;
            r_exp_function  <= mrrc_pkg::RST_FUNCTION;
            r_timeout_ticks <= mrrc_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mrrc_pkg::CFG_ADDRESS:  r_exp_address   <= i_cfg_data[7:0];
                mrrc_pkg::CFG_FUNCTION: r_exp_function  <= i_cfg_data[7:0];
                mrrc_pkg::CFG_TIMEOUT:  r_timeout_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    mrrc_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_item          (i_data),
        .i_exp_address   (r_exp_address),
        .i_exp_function  (r_exp_function),
        .i_timeout_ticks (r_timeout_ticks),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    // Output register: loads a new result or empties once the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// File: src/mrrc_checker.sv
// Port-level assertions for the Modbus read response checker, with its bind.
`default_nettype none

module mrrc_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           o_stall,
    input  wire logic           o_valid,
    input  wire logic           i_stall,
    input  wire mrrc_pkg::t_out o_data
);

    // A result word held by the receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result word changed while stalled");

    // The input is stalled exactly when a result waits on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow the output register");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == mrrc_pkg::STATUS_OK ||
                     o_data.status == mrrc_pkg::STATUS_CRC ||
                     o_data.status == mrrc_pkg::STATUS_TIME))
        else $error("undefined status code");

    // A timeout result carries no reading.
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == mrrc_pkg::STATUS_TIME |-> o_data.reading == 32'd0)
        else $error("timeout result with a non-zero reading");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

bind modbus_read_response_checker mrrc_checker u_mrrc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the Modbus read response checker: frames, ticks and noise.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 4;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    logic                                 i_clk       = 1'b0;
    logic                                 i_rst_n     = 1'b0;
    logic                                 i_valid     = 1'b0;
    logic                                 o_stall;
    mrrc_pkg::t_in                        i_data      = '0;
    logic                                 o_valid;
    logic                                 i_stall     = 1'b0;
    mrrc_pkg::t_out                       o_data;
    logic                                 i_cfg_we    = 1'b0;
    logic [mrrc_pkg::CFG_INDEX_W-1:0]     i_cfg_index = '0;
    logic [mrrc_pkg::CFG_DATA_W-1:0]      i_cfg_data  = '0;

    modbus_read_response_checker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Local copy of the configuration and of the frame tracking state.
    logic [7:0]  want_addr  = mrrc_pkg::RST_ADDRESS;
    logic [7:0]  want_func  = mrrc_pkg::RST_FUNCTION;
    logic [15:0] tick_limit = mrrc_pkg::RST_TIMEOUT;
    logic [3:0]  trk_phase  = mrrc_pkg::PH_IDLE;
    logic [15:0] trk_crc    = mrrc_pkg::CRC_INIT;
    logic [31:0] trk_data   = '0;
    logic [7:0]  trk_crc_lo = '0;
    logic [15:0] trk_ticks  = '0;

    mrrc_pkg::t_in  word_queue[$];
    mrrc_pkg::t_out due_results[$];

    int fail_count     = 0;
    int words_accepted = 0;
    int results_seen   = 0;
    int n_good         = 0;
    int n_crc_bad      = 0;
    int n_timeout      = 0;
    int settings_run   = 1;

    int burst_left = 0;
    int gap_left   = 0;
    int hold_left  = 0;

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial begin
        #RUN_LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Reflected CRC-16 over one byte, least significant bit first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? mrrc_pkg::CRC_POLY : 16'h0000);
        return r;
    endfunction

    function automatic void clear_frame();
        trk_phase  = mrrc_pkg::PH_IDLE;
        trk_crc    = mrrc_pkg::CRC_INIT;
        trk_data   = '0;
        trk_crc_lo = '0;
        trk_ticks  = '0;
    endfunction

    // Follows the frame through one accepted word and queues any result it causes.
    function automatic void track_word(input mrrc_pkg::t_in w);
        mrrc_pkg::t_out res;
        res = '0;
        if (trk_phase == mrrc_pkg::PH_IDLE || trk_phase > mrrc_pkg::PH_CRC_HI) begin
            if (w.req_type == mrrc_pkg::REQ_BYTE && w.rx_byte == want_addr) begin
                clear_frame();
                trk_crc   = crc16_byte(mrrc_pkg::CRC_INIT, w.rx_byte);
                trk_phase = mrrc_pkg::PH_FUNC;
            end
        end else if (w.req_type == mrrc_pkg::REQ_TICK) begin
            if (trk_ticks != mrrc_pkg::TICKS_MAX) trk_ticks++;
            if (trk_ticks > tick_limit) begin
                clear_frame();
                res.status = mrrc_pkg::STATUS_TIME;
                due_results.push_back(res);
            end
        end else begin
            case (trk_phase)
                mrrc_pkg::PH_CRC_LO: begin
                    trk_crc_lo = w.rx_byte;
                    trk_phase  = mrrc_pkg::PH_CRC_HI;
                end
                mrrc_pkg::PH_CRC_HI: begin
                    res.reading = trk_data;
                    res.status  = ({w.rx_byte, trk_crc_lo} == trk_crc) ?
                                  mrrc_pkg::STATUS_OK : mrrc_pkg::STATUS_CRC;
                    due_results.push_back(res);
                    clear_frame();
                end
                default: begin
                    // A wrong function code or byte count drops the frame silently.
                    if ((trk_phase == mrrc_pkg::PH_FUNC && w.rx_byte != want_func) ||
                        (trk_phase == mrrc_pkg::PH_COUNT &&
                         w.rx_byte != mrrc_pkg::BYTE_COUNT)) begin
                        clear_frame();
                    end else begin
                        if (trk_phase >= mrrc_pkg::PH_DATA0) begin
                            trk_data = {trk_data[23:0], w.rx_byte};
                        end
                        trk_crc   = crc16_byte(trk_crc, w.rx_byte);
                        trk_phase = trk_phase + 4'd1;
                    end
                end
            endcase
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        mrrc_pkg::t_in w;
        w.req_type = mrrc_pkg::REQ_BYTE;
        w.rx_byte  = b;
        word_queue.push_back(w);
    endfunction

    // The byte field of a tick carries random bits, which the block ignores.
    function automatic void queue_tick();
        mrrc_pkg::t_in w;
        w.req_type = mrrc_pkg::REQ_TICK;
        w.rx_byte  = 8'($urandom);
        word_queue.push_back(w);
    endfunction

    function automatic logic [31:0] draw_reading();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'h0000_0000;
        if (pick == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Queues the first keep_bytes bytes of a response frame for the current address and
    // function. A non-zero spoil_at flips one bit of that byte; ticks land inside the frame.
    function automatic void queue_frame(input logic [31:0] value, input int ticks_in,
                                        input int spoil_at, input int keep_bytes);
        logic [7:0]  fr [9];
        logic [15:0] acc;
        int          tick_at [9] = '{default: 0};
        fr[0] = want_addr;
        fr[1] = want_func;
        fr[2] = mrrc_pkg::BYTE_COUNT;
        fr[3] = value[31:24];
        fr[4] = value[23:16];
        fr[5] = value[15:8];
        fr[6] = value[7:0];
        acc = mrrc_pkg::CRC_INIT;
        for (int i = 0; i < 7; i++) acc = crc16_byte(acc, fr[i]);
        fr[7] = acc[7:0];
        fr[8] = acc[15:8];
        if (spoil_at != 0) fr[spoil_at] ^= 8'h01 << $urandom_range(0, 7);
        if (keep_bytes > 1) begin
            for (int t = 0; t < ticks_in; t++) tick_at[$urandom_range(1, keep_bytes - 1)]++;
        end
        for (int i = 0; i < keep_bytes; i++) begin
            repeat (tick_at[i]) queue_tick();
            queue_byte(fr[i]);
        end
    endfunction

    // Waits until every word is taken and every result has come, then lets the block settle.
    task automatic wait_quiet();
        do begin
            @(posedge i_clk);
            #1;
        end while (word_queue.size() != 0 || i_valid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mrrc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            mrrc_pkg::CFG_ADDRESS:  want_addr  = value[7:0];
            mrrc_pkg::CFG_FUNCTION: want_func  = value[7:0];
            mrrc_pkg::CFG_TIMEOUT:  tick_limit = value;
            default: ;
        endcase
    endtask

    // One register setting followed by random traffic, mostly well-formed frames.
    task automatic run_phase(input logic [7:0] addr, input logic [7:0] func,
                             input logic [15:0] limit, input int target);
        int planned;
        int pick;
        int k;
        int n;
        write_reg(mrrc_pkg::CFG_ADDRESS, {8'h00, addr});
        write_reg(mrrc_pkg::CFG_FUNCTION, {8'h00, func});
        write_reg(mrrc_pkg::CFG_TIMEOUT, limit);
        settings_run++;
        planned = 0;
        while (planned < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                // Whole frame, sometimes with ticks inside or one flipped bit.
                k = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
                queue_frame(draw_reading(), k, n, 9);
                planned += 9 + k;
            end else if (pick < 80) begin
                // Unfinished frame, then enough ticks to time out where the limit is low.
                k = $urandom_range(1, 8);
                queue_frame(draw_reading(), 0, 0, k);
                n = (limit < 40) ? int'(limit) + 1 : $urandom_range(1, 5);
                repeat (n) queue_tick();
                planned += k + n;
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 4)) begin
                    queue_byte(($urandom_range(0, 3) == 0) ? want_addr : 8'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 3)) queue_tick();
            end
        end
        wait_quiet();
    endtask

    // Sender: bursts of random length with random gaps; a stalled word is held.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_valid && !o_stall) begin
                track_word(i_data);
                words_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0 || word_queue.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    i_data  <= word_queue.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // Receiver: checks each result word against the oldest expectation and stalls
    // in runs of its own.
    always @(posedge i_clk) begin
        mrrc_pkg::t_out head;
        int             pick;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    $error("unexpected result: reading %h, status %0d", o_data.reading,
                           o_data.status);
                    fail_count++;
                end else begin
                    head = due_results.pop_front();
                    if (o_data.reading !== head.reading) begin
                        $error("reading: expected %h, got %h", head.reading, o_data.reading);
                        fail_count++;
                    end
                    if (o_data.status !== head.status) begin
                        $error("status: expected %0d, got %0d", head.status, o_data.status);
                        fail_count++;
                    end
                    case (head.status)
                        mrrc_pkg::STATUS_OK:  n_good++;
                        mrrc_pkg::STATUS_CRC: n_crc_bad++;
                        default:              n_timeout++;
                    endcase
                end
            end
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    i_stall   <= 1'b0;
                    hold_left = $urandom_range(1, 30);
                end else if (pick < 8) begin
                    i_stall   <= 1'b1;
                    hold_left = $urandom_range(1, 4);
                end else begin
                    i_stall   <= 1'b1;
                    hold_left = $urandom_range(5, 15);
                end
            end
        end
    end

    // Main sequence: reset, directed frames at reset settings, then random phases.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tick while idle, then a good frame with an all-ones reading.
        queue_tick();
        queue_frame(32'hFFFF_FFFF, 0, 0, 9);
        // Wrong function code equal to the address: it must not restart a frame.
        queue_byte(mrrc_pkg::RST_ADDRESS);
        queue_byte(mrrc_pkg::RST_ADDRESS);
        // Wrong byte count.
        queue_byte(mrrc_pkg::RST_ADDRESS);
        queue_byte(mrrc_pkg::RST_FUNCTION);
        queue_byte(mrrc_pkg::BYTE_COUNT + 8'h01);
        // Zero reading with a damaged CRC high byte.
        queue_frame(32'h0000_0000, 0, 8, 9);
        wait_quiet();

        run_phase(8'h00, 8'h00, 16'h0000, 300);
        run_phase(8'hFF, 8'hFF, 16'hFFFF, 300);
        run_phase(mrrc_pkg::RST_ADDRESS, mrrc_pkg::RST_FUNCTION, mrrc_pkg::RST_TIMEOUT, 300);
        repeat (3) run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(1, 20)), 300);

        $display("Run took %0d input words over %0d register settings.", words_accepted,
                 settings_run);
        $display("Results checked: %0d good frames, %0d CRC errors, %0d timeouts.", n_good,
                 n_crc_bad, n_timeout);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
